// File: sv/lchs_pkg.sv
// Shared constants for the lane command handshake sequencer.
// Holds command codes, lane control bit masks and beat field widths.
// No dependencies.
package lchs_pkg;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CMD_W       = 8;
  localparam int unsigned SPD_W       = 6;
  localparam int unsigned CTRL_W      = 8;
  localparam int unsigned OVR_W       = 10;
  localparam int unsigned STAT_W      = 3;

  localparam logic [CMD_W-1:0] CMD_PU_TX       = 8'd1;
  localparam logic [CMD_W-1:0] CMD_PU_RX       = 8'd2;
  localparam logic [CMD_W-1:0] CMD_PU_ALL      = 8'd3;
  localparam logic [CMD_W-1:0] CMD_PD_TX       = 8'd4;
  localparam logic [CMD_W-1:0] CMD_PD_RX       = 8'd5;
  localparam logic [CMD_W-1:0] CMD_PD_BOTH     = 8'd6;
  localparam logic [CMD_W-1:0] CMD_SPD_TX      = 8'd7;
  localparam logic [CMD_W-1:0] CMD_SPD_RX      = 8'd8;
  localparam logic [CMD_W-1:0] CMD_SPD_BOTH    = 8'd9;
  localparam logic [CMD_W-1:0] CMD_RST_TX      = 8'd10;
  localparam logic [CMD_W-1:0] CMD_RST_RX      = 8'd11;
  localparam logic [CMD_W-1:0] CMD_RST_BOTH    = 8'd12;
  localparam logic [CMD_W-1:0] CMD_RX_INIT     = 8'd13;
  localparam logic [CMD_W-1:0] CMD_TX_TRAIN    = 8'd14;
  localparam logic [CMD_W-1:0] CMD_RX_TRAIN    = 8'd15;

  localparam logic [OVR_W-1:0] M_PU_TX  = 10'h001;
  localparam logic [OVR_W-1:0] M_PU_RX  = 10'h002;
  localparam logic [OVR_W-1:0] M_PU_PLL = 10'h004;
  localparam logic [OVR_W-1:0] M_RST_TX = 10'h008;
  localparam logic [OVR_W-1:0] M_RST_RX = 10'h010;
  localparam logic [OVR_W-1:0] M_RXINIT = 10'h020;
  localparam logic [OVR_W-1:0] M_TXTRN  = 10'h040;
  localparam logic [OVR_W-1:0] M_RXTRN  = 10'h080;
  localparam logic [OVR_W-1:0] M_GEN_TX = 10'h100;
  localparam logic [OVR_W-1:0] M_GEN_RX = 10'h200;

endpackage

// File: sv/lane_command_handshake_sequencer_unit.sv
// Lane command handshake sequencer, top level.
// Uses lchs_pkg for command codes and control bit masks.
// Path: the input beat is captured in the input register, then the result in the state/result register.
// Throughput: one beat per cycle unless out_tready stalls; the state registers double as the result register.
// Reset: synchronous active-low rst_n clears the done flag, controls, overrides,
//   speeds, status and both valid flags.
module lane_command_handshake_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // command[7:0], speed_code[13:8], pll_ready_tx[14], pll_ready_rx[15],
  // rx_init_done[16], tx_train_complete[17], tx_train_failed[18],
  // tx_train_error[20:19], rx_train_complete[21], rx_train_failed[22], zero[23]
  input  logic [lchs_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // lane_controls[7:0], override_mask[17:8], tx_speed[23:18], rx_speed[29:24],
  // local_status[32:30], command_done[33], zero[39:34]
  output logic [lchs_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import lchs_pkg::*;

  logic                  in_valid_r;
  logic [IN_TDATA_W-1:0] in_data_r;
  logic                  out_valid_r;
  logic                  adv;

  logic                  done_r, done_nxt;
  logic [CTRL_W-1:0]     ctrl_r, ctrl_nxt;
  logic [OVR_W-1:0]      ovr_r, ovr_nxt;
  logic [SPD_W-1:0]      tx_spd_r, tx_spd_nxt;
  logic [SPD_W-1:0]      rx_spd_r, rx_spd_nxt;
  logic [STAT_W-1:0]     stat_r, stat_nxt;

  logic [CMD_W-1:0]      cmd;
  logic [SPD_W-1:0]      spd;
  logic                  rtx, rrx, initd, txc, txf, rxc, rxf;
  logic [1:0]            txe;

  logic [OVR_W-1:0]      set_m, clr_m, ovr_m;
  logic                  ld_tx, ld_rx, cond, defined, hs_clr;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  assign cmd   = in_data_r[7:0];
  assign spd   = in_data_r[13:8];
  assign rtx   = in_data_r[14];
  assign rrx   = in_data_r[15];
  assign initd = in_data_r[16];
  assign txc   = in_data_r[17];
  assign txf   = in_data_r[18];
  assign txe   = in_data_r[20:19];
  assign rxc   = in_data_r[21];
  assign rxf   = in_data_r[22];

  always_comb begin
    set_m    = '0;
    clr_m    = '0;
    ovr_m    = '0;
    ld_tx    = 1'b0;
    ld_rx    = 1'b0;
    cond     = 1'b0;
    defined  = 1'b1;
    hs_clr   = 1'b0;
    stat_nxt = stat_r;
    case (cmd)
      CMD_PU_TX: begin
        set_m = M_PU_TX; clr_m = M_RST_TX; ovr_m = M_PU_TX | M_GEN_TX | M_RST_TX;
        ld_tx = 1'b1; cond = rtx;
      end
      CMD_PU_RX: begin
        set_m = M_PU_RX; clr_m = M_RST_RX; ovr_m = M_PU_RX | M_GEN_RX | M_RST_RX;
        ld_rx = 1'b1; cond = rrx;
      end
      CMD_PU_ALL: begin
        set_m = M_PU_TX | M_PU_RX | M_PU_PLL;
        clr_m = M_RST_TX | M_RST_RX;
        ovr_m = M_PU_TX | M_PU_RX | M_PU_PLL | M_GEN_TX | M_GEN_RX | M_RST_TX | M_RST_RX;
        ld_tx = 1'b1; ld_rx = 1'b1; cond = rtx && rrx;
      end
      CMD_PD_TX: begin
        clr_m = M_PU_TX; ovr_m = M_PU_TX; cond = !rtx;
      end
      CMD_PD_RX: begin
        clr_m = M_PU_RX; ovr_m = M_PU_RX; cond = !rrx;
      end
      CMD_PD_BOTH: begin
        clr_m = M_PU_TX | M_PU_RX; ovr_m = M_PU_TX | M_PU_RX; cond = !rtx && !rrx;
      end
      CMD_SPD_TX: begin
        ovr_m = M_GEN_TX; ld_tx = 1'b1; cond = rtx;
      end
      CMD_SPD_RX: begin
        ovr_m = M_GEN_RX; ld_rx = 1'b1; cond = rrx;
      end
      CMD_SPD_BOTH: begin
        ovr_m = M_GEN_TX | M_GEN_RX; ld_tx = 1'b1; ld_rx = 1'b1; cond = rtx && rrx;
      end
      CMD_RST_TX: begin
        set_m = M_RST_TX; ovr_m = M_RST_TX; cond = !rtx;
      end
      CMD_RST_RX: begin
        set_m = M_RST_RX; ovr_m = M_RST_RX; cond = !rrx;
      end
      CMD_RST_BOTH: begin
        set_m = M_RST_TX | M_RST_RX; ovr_m = M_RST_TX | M_RST_RX; cond = !rtx && !rrx;
      end
      CMD_RX_INIT: begin
        cond = initd;
        if (done_r) begin
          set_m = M_RXINIT; ovr_m = M_RXINIT;
        end else if (initd) begin
          clr_m  = M_RXINIT;
          hs_clr = 1'b1;
        end
      end
      CMD_TX_TRAIN: begin
        cond = txc;
        if (done_r) begin
          set_m = M_TXTRN; ovr_m = M_TXTRN;
        end else if (txc) begin
          clr_m    = M_TXTRN;
          hs_clr   = 1'b1;
          stat_nxt = {txe, txf};
        end
      end
      CMD_RX_TRAIN: begin
        cond = rxc;
        if (done_r) begin
          set_m = M_RXTRN; ovr_m = M_RXTRN;
        end else if (rxc) begin
          clr_m    = M_RXTRN;
          hs_clr   = 1'b1;
          stat_nxt = {2'b00, rxf};
        end
      end
      default: begin
        defined = 1'b0;
      end
    endcase

    // apply command actions only when the previous handshake finished; otherwise wait for its completion condition
    ctrl_nxt   = ctrl_r;
    ovr_nxt    = ovr_r;
    tx_spd_nxt = tx_spd_r;
    rx_spd_nxt = rx_spd_r;
    done_nxt   = done_r;
    if (defined) begin
      if (done_r) begin
        ctrl_nxt = (ctrl_r | set_m[CTRL_W-1:0]) & ~clr_m[CTRL_W-1:0];
        ovr_nxt  = ovr_r | ovr_m;
        if (ld_tx) tx_spd_nxt = spd;
        if (ld_rx) rx_spd_nxt = spd;
        done_nxt = 1'b0;
      end else begin
        if (hs_clr) ctrl_nxt = ctrl_r & ~clr_m[CTRL_W-1:0];
        if (cond) done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      ctrl_r      <= '0;
      ovr_r       <= '0;
      tx_spd_r    <= '0;
      rx_spd_r    <= '0;
      stat_r      <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        done_r      <= done_nxt;
        ctrl_r      <= ctrl_nxt;
        ovr_r       <= ovr_nxt;
        tx_spd_r    <= tx_spd_nxt;
        rx_spd_r    <= rx_spd_nxt;
        stat_r      <= stat_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, done_r, stat_r, rx_spd_r, tx_spd_r, ovr_r, ctrl_r};

`ifndef ASSERT_OFF
  a_ovr_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((ovr_r & $past(ovr_r)) == $past(ovr_r)))
    else $error("override bit cleared");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(adv)) |-> ($stable(done_r) && $stable(ctrl_r) && $stable(stat_r)))
    else $error("state changed without a beat");

  a_done_defined: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !defined) |=> ($stable(done_r) && $stable(ovr_r)))
    else $error("undefined command changed state");
`endif

endmodule

// File: test/lane_command_handshake_sequencer_unit_tb.sv
// Self-checking testbench for lane_command_handshake_sequencer_unit: directed command
// cycles, then random poll ticks with stalls on both sides, checked beat by beat.
// Depends on lchs_pkg and the sequencer RTL.
module lane_command_handshake_sequencer_unit_tb;
  import lchs_pkg::*;

  typedef struct packed {
    logic              rx_train_failed;
    logic              rx_train_complete;
    logic [1:0]        tx_train_error;
    logic              tx_train_failed;
    logic              tx_train_complete;
    logic              rx_init_done;
    logic              pll_ready_rx;
    logic              pll_ready_tx;
    logic [SPD_W-1:0]  speed_code;
    logic [CMD_W-1:0]  command;
  } poll_tick_t;

  typedef struct packed {
    logic              command_done;
    logic [STAT_W-1:0] local_status;
    logic [SPD_W-1:0]  rx_speed;
    logic [SPD_W-1:0]  tx_speed;
    logic [OVR_W-1:0]  override_mask;
    logic [CTRL_W-1:0] lane_controls;
  } lane_report_t;

  localparam int TICK_W = $bits(poll_tick_t);

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // command, speed_code, pll_ready_tx, pll_ready_rx, rx_init_done, tx_train_complete,
  // tx_train_failed, tx_train_error, rx_train_complete, rx_train_failed, zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // lane_controls, override_mask, tx_speed, rx_speed, local_status, command_done, zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  lane_command_handshake_sequencer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  logic              lane_done;
  logic [CTRL_W-1:0] lane_ctrl;
  logic [OVR_W-1:0]  lane_ovr;
  logic [SPD_W-1:0]  tx_gen;
  logic [SPD_W-1:0]  rx_gen;
  logic [STAT_W-1:0] lane_stat;

  lane_report_t lane_report_q[$];
  int           fail_count;
  int           sender_gap_pct;
  int           receiver_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void drive_controls(logic [OVR_W-1:0] set_m, logic [OVR_W-1:0] clr_m,
                                         logic [OVR_W-1:0] ovr_m);
    lane_ctrl = (lane_ctrl | set_m[CTRL_W-1:0]) & ~clr_m[CTRL_W-1:0];
    lane_ovr  = lane_ovr | ovr_m;
  endfunction

  function automatic lane_report_t predict_poll_tick(poll_tick_t t);
    lane_report_t r;
    logic armed;
    logic met;
    armed = lane_done;
    met   = 1'b0;
    case (t.command)
      CMD_PU_TX: begin
        if (armed) begin
          drive_controls(M_PU_TX, M_RST_TX, M_PU_TX | M_GEN_TX | M_RST_TX);
          tx_gen = t.speed_code;
        end
        met = t.pll_ready_tx;
      end
      CMD_PU_RX: begin
        if (armed) begin
          drive_controls(M_PU_RX, M_RST_RX, M_PU_RX | M_GEN_RX | M_RST_RX);
          rx_gen = t.speed_code;
        end
        met = t.pll_ready_rx;
      end
      CMD_PU_ALL: begin
        if (armed) begin
          drive_controls(M_PU_TX | M_PU_RX | M_PU_PLL, M_RST_TX | M_RST_RX,
                         M_PU_TX | M_PU_RX | M_PU_PLL | M_GEN_TX | M_GEN_RX |
                         M_RST_TX | M_RST_RX);
          tx_gen = t.speed_code;
          rx_gen = t.speed_code;
        end
        met = t.pll_ready_tx && t.pll_ready_rx;
      end
      CMD_PD_TX: begin
        if (armed) drive_controls('0, M_PU_TX, M_PU_TX);
        met = !t.pll_ready_tx;
      end
      CMD_PD_RX: begin
        if (armed) drive_controls('0, M_PU_RX, M_PU_RX);
        met = !t.pll_ready_rx;
      end
      CMD_PD_BOTH: begin
        if (armed) drive_controls('0, M_PU_TX | M_PU_RX, M_PU_TX | M_PU_RX);
        met = !t.pll_ready_tx && !t.pll_ready_rx;
      end
      CMD_SPD_TX: begin
        if (armed) begin
          drive_controls('0, '0, M_GEN_TX);
          tx_gen = t.speed_code;
        end
        met = t.pll_ready_tx;
      end
      CMD_SPD_RX: begin
        if (armed) begin
          drive_controls('0, '0, M_GEN_RX);
          rx_gen = t.speed_code;
        end
        met = t.pll_ready_rx;
      end
      CMD_SPD_BOTH: begin
        if (armed) begin
          drive_controls('0, '0, M_GEN_TX | M_GEN_RX);
          tx_gen = t.speed_code;
          rx_gen = t.speed_code;
        end
        met = t.pll_ready_tx && t.pll_ready_rx;
      end
      CMD_RST_TX: begin
        if (armed) drive_controls(M_RST_TX, '0, M_RST_TX);
        met = !t.pll_ready_tx;
      end
      CMD_RST_RX: begin
        if (armed) drive_controls(M_RST_RX, '0, M_RST_RX);
        met = !t.pll_ready_rx;
      end
      CMD_RST_BOTH: begin
        if (armed) drive_controls(M_RST_TX | M_RST_RX, '0, M_RST_TX | M_RST_RX);
        met = !t.pll_ready_tx && !t.pll_ready_rx;
      end
      CMD_RX_INIT: begin
        if (armed) drive_controls(M_RXINIT, '0, M_RXINIT);
        else if (t.rx_init_done) drive_controls('0, M_RXINIT, '0);
        met = t.rx_init_done;
      end
      CMD_TX_TRAIN: begin
        if (armed) drive_controls(M_TXTRN, '0, M_TXTRN);
        else if (t.tx_train_complete) begin
          lane_stat = {t.tx_train_error, t.tx_train_failed};
          drive_controls('0, M_TXTRN, '0);
        end
        met = t.tx_train_complete;
      end
      CMD_RX_TRAIN: begin
        if (armed) drive_controls(M_RXTRN, '0, M_RXTRN);
        else if (t.rx_train_complete) begin
          lane_stat = {2'b00, t.rx_train_failed};
          drive_controls('0, M_RXTRN, '0);
        end
        met = t.rx_train_complete;
      end
      default: armed = 1'b0;
    endcase
    if (armed) lane_done = 1'b0;
    else if (met) lane_done = 1'b1;
    r.lane_controls = lane_ctrl;
    r.override_mask = lane_ovr;
    r.tx_speed      = tx_gen;
    r.rx_speed      = rx_gen;
    r.local_status  = lane_stat;
    r.command_done  = lane_done;
    return r;
  endfunction

  function automatic poll_tick_t random_tick(logic [CMD_W-1:0] code);
    poll_tick_t t;
    t = poll_tick_t'(TICK_W'($urandom));
    t.command = code;
    return t;
  endfunction

  function automatic poll_tick_t force_completion(poll_tick_t t);
    case (t.command)
      CMD_PU_TX, CMD_SPD_TX: t.pll_ready_tx = 1'b1;
      CMD_PU_RX, CMD_SPD_RX: t.pll_ready_rx = 1'b1;
      CMD_PU_ALL, CMD_SPD_BOTH: begin
        t.pll_ready_tx = 1'b1;
        t.pll_ready_rx = 1'b1;
      end
      CMD_PD_TX, CMD_RST_TX: t.pll_ready_tx = 1'b0;
      CMD_PD_RX, CMD_RST_RX: t.pll_ready_rx = 1'b0;
      CMD_PD_BOTH, CMD_RST_BOTH: begin
        t.pll_ready_tx = 1'b0;
        t.pll_ready_rx = 1'b0;
      end
      CMD_RX_INIT:  t.rx_init_done = 1'b1;
      CMD_TX_TRAIN: t.tx_train_complete = 1'b1;
      CMD_RX_TRAIN: t.rx_train_complete = 1'b1;
      default: ;
    endcase
    return t;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    lane_report_t got;
    lane_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(lane_report_t)-1:0];
      if (lane_report_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = lane_report_q.pop_front();
        check_field("lane_controls", 32'(want.lane_controls), 32'(got.lane_controls));
        check_field("override_mask", 32'(want.override_mask), 32'(got.override_mask));
        check_field("tx_speed", 32'(want.tx_speed), 32'(got.tx_speed));
        check_field("rx_speed", 32'(want.rx_speed), 32'(got.rx_speed));
        check_field("local_status", 32'(want.local_status), 32'(got.local_status));
        check_field("command_done", 32'(want.command_done), 32'(got.command_done));
        check_field("pad", 0, 32'(out_tdata[OUT_TDATA_W-1:$bits(lane_report_t)]));
      end
    end
  end

  task automatic send_tick(poll_tick_t t);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_TDATA_W'(t);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lane_report_q.push_back(predict_poll_tick(t));
    @(negedge clk);
  endtask

  task automatic wait_for_reports();
    in_tvalid = 1'b0;
    while (lane_report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_undefined_codes();
    poll_tick_t t;
    t = poll_tick_t'('0);
    send_tick(t);
    t = poll_tick_t'('1);
    send_tick(t);
    t = random_tick(CMD_W'(16));
    send_tick(t);
  endtask

  task automatic test_command_cycle();
    poll_tick_t t;
    logic [CMD_W-1:0] code;
    // wait on power-down must hold while the TX PLL still reports ready
    t = random_tick(CMD_PD_TX);
    t.pll_ready_tx = 1'b1;
    send_tick(t);
    for (code = CMD_PU_TX; code <= CMD_RX_TRAIN; code++) begin
      t = force_completion(random_tick(code));
      if (code == CMD_TX_TRAIN) begin
        t.tx_train_failed = 1'b1;
        t.tx_train_error  = 2'b11;
      end
      send_tick(t);
      t = random_tick(code);
      t.speed_code = code[0] ? '1 : '0;
      send_tick(t);
    end
  endtask

  task automatic test_training_and_init();
    poll_tick_t t;
    t = force_completion(random_tick(CMD_RX_TRAIN));
    t.rx_train_failed = 1'b1;
    send_tick(t);
    send_tick(random_tick(CMD_RX_INIT));
    send_tick(force_completion(random_tick(CMD_RX_INIT)));
    wait_for_reports();
  endtask

  task automatic test_random_traffic(int gap_pct, int stall_pct, int n_cmds);
    poll_tick_t t;
    int sent;
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_cmds) begin
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 1) != 0) send_tick(random_tick('0));
        else send_tick(random_tick(CMD_W'($urandom_range(16, 255))));
      end else begin
        t = random_tick(CMD_W'($urandom_range(1, 15)));
        if ($urandom_range(0, 1) != 0) t = force_completion(t);
        send_tick(t);
        sent++;
        if (sent == n_cmds / 2) wait_for_reports();
      end
    end
    wait_for_reports();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    fail_count         = 0;
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    lane_done          = 1'b0;
    lane_ctrl          = '0;
    lane_ovr           = '0;
    tx_gen             = '0;
    rx_gen             = '0;
    lane_stat          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_undefined_codes();
    test_command_cycle();
    test_training_and_init();
    test_random_traffic(32, 67, 490);
    test_random_traffic(67, 32, 490);
    test_random_traffic(0, 0, 490);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: lane_command_handshake_sequencer_unit.f
sv/lchs_pkg.sv
sv/lane_command_handshake_sequencer_unit.sv
test/lane_command_handshake_sequencer_unit_tb.sv
